FILE: rtl/bpe_pkg.sv
// Shared types and codes for the path point engine.
package bpe_pkg;

  // Function codes of an input item
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_EVAL  = 2'd1;
  localparam logic [1:0] FUNC_HIT   = 2'd2;

  // Hit kinds
  localparam logic [1:0] KIND_ANCHOR = 2'd0;
  localparam logic [1:0] KIND_IN     = 2'd1;
  localparam logic [1:0] KIND_OUT    = 2'd2;

  // One table entry, all Q12.4
  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] ix;
    logic signed [15:0] iy;
    logic signed [15:0] ox;
    logic signed [15:0] oy;
  } point_t;

  // Write port of the point table
  typedef struct packed {
    logic   en;
    point_t data;
  } tbl_wr_t;

endpackage

FILE: rtl/bpe_table.sv
// Point table memory: one write port, one read port with registered data.
module bpe_table import bpe_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic              clk,
  input  tbl_wr_t           wr,
  input  logic [AW-1:0]     wr_addr,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output point_t            rd_data
);

  point_t mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
  end

  // Read one entry, data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/bezier_path_point_engine_core.sv
// Top level of the piecewise cubic Bezier path point engine.
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------
//  cfg      | cfg_wr_en              | cfg_wr_data (point_count)
//  input    | in_valid / in_ready    | func, entry_index, point, t, query
//  output   | out_valid / out_ready  | curve_x, curve_y, hit_found/index/kind
//
// Write and unknown items go straight to the done state. Evaluate items pass
// through segment select, weight multiplies, two table reads, four shared
// multiply-accumulate steps and a round. Hit tests walk one entry at a time
// on the single table read port; one distance unit is shared by its three handles.
// Reset (rst, synchronous) sets point_count to 2; the table is not cleared.
// A result waits in the output register; the next item is accepted meanwhile.
module bezier_path_point_engine_core import bpe_pkg::*; #(
  parameter int MAX_POINTS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [5:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic [4:0]         entry_index,
  input  logic signed [15:0] anchor_x,
  input  logic signed [15:0] anchor_y,
  input  logic signed [15:0] in_handle_x,
  input  logic signed [15:0] in_handle_y,
  input  logic signed [15:0] out_handle_x,
  input  logic signed [15:0] out_handle_y,
  input  logic [16:0]        param_t,
  input  logic signed [15:0] query_x,
  input  logic signed [15:0] query_y,
  input  logic [14:0]        radius,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] curve_x,
  output logic signed [15:0] curve_y,
  output logic               hit_found,
  output logic [4:0]         hit_index,
  output logic [1:0]         hit_kind
);

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int CWM = $clog2(MAX_POINTS + 1);
  localparam int CW  = (CWM > 6) ? CWM : 6;
  localparam int SW  = 17 + CW;

  typedef enum logic [3:0] {
    S_IDLE, S_SEG, S_MUL1, S_MUL2, S_MAC, S_RND, S_HRD, S_HCMP, S_DONE
  } state_t;

  state_t state;
  logic [5:0] point_count;

  // Item registers
  logic [16:0]        t_r;
  logic signed [15:0] qx, qy;
  logic [29:0]        r2;
  logic [AW-1:0]      idx;
  logic [1:0]         kind;
  logic [1:0]         step;
  logic [AW-1:0]      seg;
  logic [16:0]        lt, u;
  logic [33:0]        p1, p2;
  logic [50:0]        w0, w3, m1, m2;
  point_t             pa;
  logic signed [65:0] acc_x, acc_y;

  // Result staging
  logic signed [15:0] res_x, res_y;
  logic               res_found;
  logic [4:0]         res_idx;
  logic [1:0]         res_kind;

  // Table ports
  tbl_wr_t       tbl_wr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  point_t        rd_data;

  // Clamp the point count and derive segment count
  logic [CW-1:0] n_use, segs;
  always_comb begin
    n_use = CW'(point_count);
    if (n_use < CW'(2)) n_use = CW'(2);
    if (n_use > CW'(MAX_POINTS)) n_use = CW'(MAX_POINTS);
    segs = n_use - CW'(1);
  end

  // Segment index and local parameter
  logic [SW-1:0] scaled;
  logic [SW-17:0] seg_raw;
  logic [SW-1:0] seg_base;
  always_comb begin
    scaled = SW'(t_r) * SW'(segs);
    seg_raw = scaled[SW-1:16];
    if (seg_raw > (SW-16)'(segs - CW'(1))) seg_raw = (SW-16)'(segs - CW'(1));
    seg_base = SW'(seg_raw) << 16;
  end

  logic in_acc;
  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // Load the output register when a result is ready and the slot is free
  logic out_load;
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  // Write port straight from the input item
  always_comb begin
    tbl_wr.en   = in_acc && (func == FUNC_WRITE) && (32'(entry_index) < MAX_POINTS);
    tbl_wr.data = '{ax: anchor_x, ay: anchor_y, ix: in_handle_x,
                    iy: in_handle_y, ox: out_handle_x, oy: out_handle_y};
  end

  // Read address per state
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = seg;
    unique case (state)
      S_MUL1:  begin rd_en = 1'b1; rd_addr = seg; end
      S_MUL2:  begin rd_en = 1'b1; rd_addr = seg + AW'(1); end
      S_HRD:   begin rd_en = 1'b1; rd_addr = idx; end
      default: begin rd_en = 1'b0; end
    endcase
  end

  // Multiply-accumulate operand select
  logic signed [15:0] cx_sel, cy_sel;
  logic [50:0]        w_sel;
  logic signed [65:0] prod_x, prod_y, w_ext;
  always_comb begin
    case (step)
      2'd0:    begin cx_sel = pa.ax;      cy_sel = pa.ay;      w_sel = w0; end
      2'd1:    begin cx_sel = pa.ox;      cy_sel = pa.oy;      w_sel = m1 + (m1 << 1); end
      2'd2:    begin cx_sel = rd_data.ix; cy_sel = rd_data.iy; w_sel = m2 + (m2 << 1); end
      default: begin cx_sel = rd_data.ax; cy_sel = rd_data.ay; w_sel = w3; end
    endcase
    w_ext  = $signed({15'b0, w_sel});
    prod_x = 66'(cx_sel) * w_ext;
    prod_y = 66'(cy_sel) * w_ext;
  end

  // Round once to Q12.4 and saturate
  function automatic logic signed [15:0] round_sat(input logic signed [65:0] a);
    logic signed [65:0] v;
    logic signed [17:0] q;
    v = a + (66'sd1 <<< 47);
    q = 18'(v >>> 48);
    if (q > 18'sd32767) return 16'sh7fff;
    if (q < -18'sd32768) return 16'sh8000;
    return q[15:0];
  endfunction

  // Distance check of one handle
  logic signed [15:0] px, py;
  logic signed [16:0] dx, dy;
  logic [34:0]        d2;
  logic               near;
  always_comb begin
    case (kind)
      KIND_OUT: begin px = rd_data.ox; py = rd_data.oy; end
      KIND_IN:  begin px = rd_data.ix; py = rd_data.iy; end
      default:  begin px = rd_data.ax; py = rd_data.ay; end
    endcase
    dx   = 17'(qx) - 17'(px);
    dy   = 17'(qy) - 17'(py);
    d2   = 35'(34'(dx * dx)) + 35'(34'(dy * dy));
    near = d2 < 35'(r2);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      point_count <= 6'd2;
    end else begin
      if (cfg_wr_en) point_count <= cfg_wr_data;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          res_x <= '0; res_y <= '0; res_found <= 1'b0;
          res_idx <= '0; res_kind <= KIND_ANCHOR;
          t_r  <= (param_t > 17'd65536) ? 17'd65536 : param_t;
          qx   <= query_x;
          qy   <= query_y;
          r2   <= 30'(radius) * 30'(radius);
          idx  <= AW'(n_use - CW'(1));
          kind <= KIND_OUT;
          step <= 2'd0;
          acc_x <= '0;
          acc_y <= '0;
          if (in_acc) begin
            case (func)
              FUNC_EVAL: state <= S_SEG;
              FUNC_HIT:  state <= S_HRD;
              default:   state <= S_DONE;
            endcase
          end
        end
        S_SEG: begin
          seg <= AW'(seg_raw);
          lt  <= 17'(scaled - seg_base);
          u   <= 17'd65536 - 17'(scaled - seg_base);
          state <= S_MUL1;
        end
        S_MUL1: begin
          p1 <= 34'(u) * 34'(u);
          p2 <= 34'(lt) * 34'(lt);
          state <= S_MUL2;
        end
        S_MUL2: begin
          w0 <= 51'(p1) * 51'(u);
          m1 <= 51'(p1) * 51'(lt);
          m2 <= 51'(p2) * 51'(u);
          w3 <= 51'(p2) * 51'(lt);
          pa <= rd_data;
          state <= S_MAC;
        end
        S_MAC: begin
          acc_x <= acc_x + prod_x;
          acc_y <= acc_y + prod_y;
          step  <= step + 2'd1;
          if (step == 2'd3) state <= S_RND;
        end
        S_RND: begin
          res_x <= round_sat(acc_x);
          res_y <= round_sat(acc_y);
          state <= S_DONE;
        end
        S_HRD: begin
          kind  <= KIND_OUT;
          state <= S_HCMP;
        end
        S_HCMP: begin
          if (near) begin
            res_found <= 1'b1;
            res_idx   <= 5'(idx);
            res_kind  <= kind;
            state     <= S_DONE;
          end else if (kind != KIND_ANCHOR) begin
            kind <= kind - 2'd1;
          end else if (idx == '0) begin
            state <= S_DONE;
          end else begin
            idx   <= idx - AW'(1);
            state <= S_HRD;
          end
        end
        S_DONE: begin
          if (out_load) begin
            curve_x   <= res_x;
            curve_y   <= res_y;
            hit_found <= res_found;
            hit_index <= res_idx;
            hit_kind  <= res_kind;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  bpe_table #(.DEPTH(MAX_POINTS), .AW(AW)) u_table (
    .clk     (clk),
    .wr      (tbl_wr),
    .wr_addr (AW'(entry_index)),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule
